// ===== rtl/wasym_pkg.sv =====
// wasym_pkg: shared types and codes for the word alignment symmetrizer
// used by wasym_ctrl, wasym_dp and word_alignment_symmetrizer; no dependencies
`timescale 1ns / 1ps

package wasym_pkg;

   localparam int MAX_SRC = 32;
   localparam int MAX_TGT = 32;

   // word actions
   localparam logic [1:0] ACT_SRC = 2'd0;
   localparam logic [1:0] ACT_TGT = 2'd1;
   localparam logic [1:0] ACT_END = 2'd2;
   localparam logic [1:0] ACT_NOP = 2'd3;

   // symmetrization modes
   localparam logic [2:0] MODE_UNION     = 3'd0;
   localparam logic [2:0] MODE_INTERSECT = 3'd1;
   localparam logic [2:0] MODE_GROW      = 3'd2;
   localparam logic [2:0] MODE_S2T       = 3'd3;
   localparam logic [2:0] MODE_T2S       = 3'd4;

   // csr indexes
   localparam logic [1:0] CSR_MODE  = 2'd0;
   localparam logic [1:0] CSR_DIAG  = 2'd1;
   localparam logic [1:0] CSR_FINAL = 2'd2;
   localparam logic [1:0] CSR_BOTH  = 2'd3;

   typedef struct packed {
      logic [1:0] action;
      logic [4:0] position;
      logic [5:0] link;
      logic [5:0] src_len;
      logic [5:0] tgt_len;
   } req_type;

   typedef struct packed {
      logic [4:0] src_index;
      logic [4:0] tgt_index;
      logic       empty_res;
      logic       error;
      logic       last;
   } rsp_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CHECK,
      OP_SRC,
      OP_TGT,
      OP_INT,
      OP_GINIT,
      OP_GSCAN,
      OP_GNEIGH,
      OP_F1,
      OP_F2,
      OP_GEMIT,
      OP_FLUSH
   } op_type;

   typedef struct packed {
      op_type op;
      logic   load;
   } cmd_type;

   typedef struct packed {
      logic       done;
      logic       hit;
      logic       nb_last;
      logic       added;
      logic       err;
      logic       slot_free;
      logic [2:0] mode;
      logic       final_step;
   } stat_type;

endpackage

// ===== rtl/wasym_ctrl.sv =====
// wasym_ctrl: sequencer for the symmetrizer phases
// depends on wasym_pkg; drives wasym_dp through cmd_type, reads stat_type
`timescale 1ns / 1ps

module wasym_ctrl import wasym_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic [1:0] req_action,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_SRC,
      S_TGT,
      S_INT,
      S_GINIT,
      S_GSCAN,
      S_GNEIGH,
      S_F1,
      S_F2,
      S_GEMIT,
      S_FLUSH
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;
   op_type    op;
   logic      accept;

   assign accept    = req_valid && ready_ff;
   assign req_ready = ready_ff;
   assign cmd.op    = op;
   assign cmd.load  = accept;

   always_comb begin
      state_in = state_ff;
      op       = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (accept && req_action == ACT_END) state_in = S_CHECK;
         end
         S_CHECK: begin
            op = OP_CHECK;
            if (stat.err) state_in = S_FLUSH;
            else begin
               case (stat.mode)
                  MODE_INTERSECT: state_in = S_INT;
                  MODE_GROW:      state_in = S_GINIT;
                  MODE_T2S:       state_in = S_TGT;
                  default:        state_in = S_SRC;
               endcase
            end
         end
         S_SRC: begin
            if (stat.slot_free) begin
               op = OP_SRC;
               if (stat.done) state_in = (stat.mode == MODE_S2T) ? S_FLUSH : S_TGT;
            end
         end
         S_TGT: begin
            if (stat.slot_free) begin
               op = OP_TGT;
               if (stat.done) state_in = S_FLUSH;
            end
         end
         S_INT: begin
            if (stat.slot_free) begin
               op = OP_INT;
               if (stat.done) state_in = S_FLUSH;
            end
         end
         S_GINIT: begin
            op = OP_GINIT;
            if (stat.done) state_in = S_GSCAN;
         end
         S_GSCAN: begin
            op = OP_GSCAN;
            if (stat.done) begin
               // another pass while the last one still added points
               if (stat.added)          state_in = S_GSCAN;
               else if (stat.final_step) state_in = S_F1;
               else                     state_in = S_GEMIT;
            end else if (stat.hit) begin
               state_in = S_GNEIGH;
            end
         end
         S_GNEIGH: begin
            op = OP_GNEIGH;
            if (stat.nb_last) state_in = S_GSCAN;
         end
         S_F1: begin
            op = OP_F1;
            if (stat.done) state_in = S_F2;
         end
         S_F2: begin
            op = OP_F2;
            if (stat.done) state_in = S_GEMIT;
         end
         S_GEMIT: begin
            if (stat.slot_free) begin
               op = OP_GEMIT;
               if (stat.done) state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            if (stat.slot_free) begin
               op       = OP_FLUSH;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      ready_in = (state_in == S_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

endmodule

// ===== rtl/wasym_dp.sv =====
// wasym_dp: link stores, chosen-point matrix, coverage, scan counters and
// result registers; depends on wasym_pkg, commanded by wasym_ctrl
`timescale 1ns / 1ps

module wasym_dp import wasym_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  req_type  req_data,
   input  cmd_type  cmd,
   input  logic     csr_we,
   input  logic [1:0] csr_index,
   input  logic [2:0] csr_wdata,
   input  logic     rsp_ready,
   output logic     rsp_valid,
   output rsp_type  rsp_data,
   output stat_type stat
);

   logic [2:0] mode_ff;
   logic       diag_ff, final_ff, both_ff;

   logic [5:0] sl_ff [MAX_SRC];
   logic [5:0] tl_ff [MAX_TGT];
   logic [MAX_SRC-1:0] chosen_ff [MAX_TGT];
   logic [MAX_SRC-1:0] scov_ff;
   logic [MAX_TGT-1:0] tcov_ff;

   logic [5:0] m_ff, n_ff, a_ff, a_in, b_ff, b_in, lk_ff, lk_in;
   logic [2:0] o_ff, o_in;
   logic       ph_ff, ph_in, added_ff, added_in;
   rsp_type    pend_ff, out_ff;
   logic       pend_valid_ff, out_valid_ff, out_valid_in;

   logic [4:0] sa, ta;
   logic [5:0] sl_q, tl_q, lim, lk_m1, a_p1;
   logic [MAX_SRC-1:0] row_q, ge_b, lt_m, scan_v, f2_v;
   logic [4:0] scan_pos, f2_pos;
   logic       done;
   logic       choose_en, found_en;
   logic [4:0] ch_t, ch_s, f_s, f_t;
   logic signed [1:0] dt, ds;
   logic signed [6:0] pt, ps;
   logic       nb_ok, nb_last;
   logic [MAX_SRC+MAX_TGT-1:0] err_vec;
   logic [MAX_TGT-1:0] row_any;

   function automatic logic [4:0] find_low(input logic [MAX_SRC-1:0] v);
      logic [4:0] idx;
      idx = '0;
      for (int i = MAX_SRC - 1; i >= 0; i--) begin
         if (v[i]) idx = 5'(i);
      end
      return idx;
   endfunction

   function automatic logic fin_ok(input logic both, input logic tc, input logic sc);
      return both ? (!tc && !sc) : !(tc && sc);
   endfunction

   // neighbour order: up, left, down, right, then the diagonals
   always_comb begin
      case (o_ff)
         3'd0:    begin dt = -2'sd1; ds =  2'sd0; end
         3'd1:    begin dt =  2'sd0; ds = -2'sd1; end
         3'd2:    begin dt =  2'sd1; ds =  2'sd0; end
         3'd3:    begin dt =  2'sd0; ds =  2'sd1; end
         3'd4:    begin dt = -2'sd1; ds = -2'sd1; end
         3'd5:    begin dt = -2'sd1; ds =  2'sd1; end
         3'd6:    begin dt =  2'sd1; ds = -2'sd1; end
         default: begin dt =  2'sd1; ds =  2'sd1; end
      endcase
   end

   assign pt = $signed({1'b0, a_ff}) + $signed({{5{dt[1]}}, dt});
   assign ps = $signed({1'b0, b_ff}) + $signed({{5{ds[1]}}, ds});
   assign nb_last = diag_ff ? (o_ff == 3'd7) : (o_ff == 3'd3);

   assign lk_m1 = lk_ff - 6'd1;
   assign a_p1  = a_ff + 6'd1;
   assign row_q = chosen_ff[a_ff[4:0]];
   assign sl_q  = sl_ff[sa];
   assign tl_q  = tl_ff[ta];

   always_comb begin
      for (int i = 0; i < MAX_SRC; i++) begin
         ge_b[i] = 6'(i) >= b_ff;
         lt_m[i] = 6'(i) < m_ff;
         f2_v[i] = (sl_ff[i] == a_p1) && ge_b[i] && lt_m[i];
         err_vec[i] = lt_m[i] && (sl_ff[i] > n_ff);
      end
      for (int i = 0; i < MAX_TGT; i++) begin
         err_vec[MAX_SRC+i] = (6'(i) < n_ff) && (tl_ff[i] > m_ff);
         row_any[i] = |chosen_ff[i];
      end
   end

   assign scan_v   = row_q & ge_b & lt_m;
   assign scan_pos = find_low(scan_v);
   assign f2_pos   = find_low(f2_v);

   assign lim  = (cmd.op == OP_SRC || cmd.op == OP_INT || cmd.op == OP_GINIT) ? m_ff : n_ff;
   assign done = !ph_ff && (a_ff >= lim);

   always_comb begin
      a_in      = a_ff;
      b_in      = b_ff;
      o_in      = o_ff;
      ph_in     = ph_ff;
      lk_in     = lk_ff;
      added_in  = added_ff;
      sa        = a_ff[4:0];
      ta        = a_ff[4:0];
      choose_en = 1'b0;
      ch_t      = '0;
      ch_s      = '0;
      found_en  = 1'b0;
      f_s       = '0;
      f_t       = '0;
      nb_ok     = 1'b0;
      case (cmd.op)
         OP_SRC: begin
            if (done) a_in = '0;
            else begin
               if (sl_q != 6'd0) begin
                  found_en = 1'b1;
                  f_s      = a_ff[4:0];
                  f_t      = 5'(sl_q - 6'd1);
               end
               a_in = a_p1;
            end
         end
         OP_INT, OP_GINIT: begin
            if (!ph_ff) begin
               if (done) a_in = '0;
               else begin
                  lk_in = sl_q;
                  ph_in = 1'b1;
               end
            end else begin
               ta = lk_m1[4:0];
               if (lk_ff != 6'd0 && tl_q == a_p1) begin
                  if (cmd.op == OP_INT) begin
                     found_en = 1'b1;
                     f_s      = a_ff[4:0];
                     f_t      = lk_m1[4:0];
                  end else begin
                     choose_en = 1'b1;
                     ch_t      = lk_m1[4:0];
                     ch_s      = a_ff[4:0];
                  end
               end
               a_in  = a_p1;
               ph_in = 1'b0;
            end
         end
         OP_TGT, OP_F1: begin
            if (!ph_ff) begin
               if (done) a_in = '0;
               else begin
                  lk_in = tl_q;
                  ph_in = 1'b1;
               end
            end else begin
               sa = lk_m1[4:0];
               if (cmd.op == OP_TGT) begin
                  if (lk_ff != 6'd0 && (mode_ff == MODE_T2S || sl_q != a_p1)) begin
                     found_en = 1'b1;
                     f_s      = lk_m1[4:0];
                     f_t      = a_ff[4:0];
                  end
               end else if (lk_ff != 6'd0 && !row_q[lk_m1[4:0]] && sl_q != a_p1 &&
                            fin_ok(both_ff, tcov_ff[a_ff[4:0]], scov_ff[lk_m1[4:0]])) begin
                  choose_en = 1'b1;
                  ch_t      = a_ff[4:0];
                  ch_s      = lk_m1[4:0];
               end
               a_in  = a_p1;
               ph_in = 1'b0;
            end
         end
         OP_GSCAN: begin
            if (done) begin
               a_in     = '0;
               b_in     = '0;
               added_in = 1'b0;
            end else if (|scan_v) begin
               b_in = {1'b0, scan_pos};
               o_in = '0;
            end else begin
               a_in = a_p1;
               b_in = '0;
            end
         end
         OP_GNEIGH: begin
            sa = ps[4:0];
            ta = pt[4:0];
            nb_ok = (pt >= 7'sd0) && (pt < $signed({1'b0, n_ff})) &&
                    (ps >= 7'sd0) && (ps < $signed({1'b0, m_ff})) &&
                    (tl_q == ps[5:0] + 6'd1 || sl_q == pt[5:0] + 6'd1) &&
                    !(tcov_ff[pt[4:0]] && scov_ff[ps[4:0]]);
            if (nb_ok) begin
               choose_en = 1'b1;
               ch_t      = pt[4:0];
               ch_s      = ps[4:0];
               added_in  = 1'b1;
            end
            if (nb_last) begin
               o_in = '0;
               b_in = b_ff + 6'd1;
            end else begin
               o_in = o_ff + 3'd1;
            end
         end
         OP_F2: begin
            if (done) begin
               a_in = '0;
               b_in = '0;
            end else if (|f2_v) begin
               if (!row_q[f2_pos] && tl_q != {1'b0, f2_pos} + 6'd1 &&
                   fin_ok(both_ff, tcov_ff[a_ff[4:0]], scov_ff[f2_pos])) begin
                  choose_en = 1'b1;
                  ch_t      = a_ff[4:0];
                  ch_s      = f2_pos;
               end
               b_in = {1'b0, f2_pos} + 6'd1;
            end else begin
               a_in = a_p1;
               b_in = '0;
            end
         end
         OP_GEMIT: begin
            if (done) begin
               a_in = '0;
               b_in = '0;
            end else if (|scan_v) begin
               found_en = 1'b1;
               f_s      = scan_pos;
               f_t      = a_ff[4:0];
               b_in     = {1'b0, scan_pos} + 6'd1;
            end else begin
               a_in = a_p1;
               b_in = '0;
            end
         end
         default: ;
      endcase
   end

   // output register loads on a released pair or a flush, else drains on ready
   assign out_valid_in = ((found_en && pend_valid_ff) || cmd.op == OP_FLUSH) ? 1'b1 :
                         (out_valid_ff && !rsp_ready);

   assign stat.done       = done;
   assign stat.hit        = |scan_v;
   assign stat.nb_last    = nb_last;
   assign stat.added      = added_ff;
   assign stat.err        = |err_vec;
   assign stat.slot_free  = !out_valid_ff || rsp_ready;
   assign stat.mode       = mode_ff;
   assign stat.final_step = final_ff;

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // csr and link stores
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_UNION;
         diag_ff  <= 1'b0;
         final_ff <= 1'b0;
         both_ff  <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MODE:  mode_ff  <= csr_wdata;
            CSR_DIAG:  diag_ff  <= csr_wdata[0];
            CSR_FINAL: final_ff <= csr_wdata[0];
            CSR_BOTH:  both_ff  <= csr_wdata[0];
            default:   ;
         endcase
      end
      if (cmd.load && req_data.action == ACT_SRC) sl_ff[req_data.position] <= req_data.link;
      if (cmd.load && req_data.action == ACT_TGT) tl_ff[req_data.position] <= req_data.link;
   end

   // matrix and coverage, cleared by each end word
   always_ff @(posedge clock) begin
      if (reset || (cmd.load && req_data.action == ACT_END)) begin
         for (int i = 0; i < MAX_TGT; i++) chosen_ff[i] <= '0;
         scov_ff <= '0;
         tcov_ff <= '0;
      end else if (choose_en) begin
         chosen_ff[ch_t][ch_s] <= 1'b1;
         tcov_ff[ch_t]         <= 1'b1;
         scov_ff[ch_s]         <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff          <= '0;
         b_ff          <= '0;
         o_ff          <= '0;
         ph_ff         <= 1'b0;
         added_ff      <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else if (cmd.load && req_data.action == ACT_END) begin
         a_ff          <= '0;
         b_ff          <= '0;
         o_ff          <= '0;
         ph_ff         <= 1'b0;
         added_ff      <= 1'b0;
         pend_valid_ff <= 1'b0;
         m_ff <= (req_data.src_len > 6'(MAX_SRC)) ? 6'(MAX_SRC) : req_data.src_len;
         n_ff <= (req_data.tgt_len > 6'(MAX_TGT)) ? 6'(MAX_TGT) : req_data.tgt_len;
         out_valid_ff  <= out_valid_in;
      end else begin
         a_ff     <= a_in;
         b_ff     <= b_in;
         o_ff     <= o_in;
         ph_ff    <= ph_in;
         lk_ff    <= lk_in;
         added_ff <= added_in;
         out_valid_ff <= out_valid_in;
         if (cmd.op == OP_CHECK && stat.err) begin
            pend_ff       <= '{src_index: '0, tgt_index: '0, empty_res: 1'b0,
                               error: 1'b1, last: 1'b0};
            pend_valid_ff <= 1'b1;
         end
         // one pair is held back so the final one can carry last
         if (found_en) begin
            if (pend_valid_ff) out_ff <= pend_ff;
            pend_ff       <= '{src_index: f_s, tgt_index: f_t, empty_res: 1'b0,
                               error: 1'b0, last: 1'b0};
            pend_valid_ff <= 1'b1;
         end
         if (cmd.op == OP_FLUSH) begin
            if (pend_valid_ff) begin
               out_ff <= '{src_index: pend_ff.src_index, tgt_index: pend_ff.tgt_index,
                           empty_res: pend_ff.empty_res, error: pend_ff.error,
                           last: 1'b1};
            end else begin
               out_ff <= '{src_index: '0, tgt_index: '0, empty_res: 1'b1,
                           error: 1'b0, last: 1'b1};
            end
            pend_valid_ff <= 1'b0;
         end
      end
   end

   a_flush_drains: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_FLUSH |=> !pend_valid_ff && out_valid_ff && rsp_data.last)
      else $error("flush did not deliver the closing word");

   a_cov_rows: assert property (@(posedge clock) disable iff (reset)
      (tcov_ff & row_any) == row_any)
      else $error("chosen row without target coverage");

   a_found_slot: assert property (@(posedge clock) disable iff (reset)
      (found_en && pend_valid_ff) |-> (!out_valid_ff || rsp_ready))
      else $error("pair pushed into a full output register");

endmodule

// ===== rtl/word_alignment_symmetrizer.sv =====
// word_alignment_symmetrizer: top level joining the sequencer and datapath
// depends on wasym_pkg, wasym_ctrl and wasym_dp
`timescale 1ns / 1ps

// Link words (source or target side) are taken one per clock while idle and
// only write the link stores. An end word closes the sentence: a check state
// tests every link against the lengths, then the chosen mode runs, or a bad
// link sends a single error word. Union, intersection and the two directed
// modes scan the links word by word, following a link into the other store
// where needed. Grow first seeds the intersection from the source words, then
// scans the matrix row by row and checks the four or eight neighbours of each
// chosen point in each raster pass, repeating passes until one adds nothing;
// the final step, if enabled, follows the target links and then the source
// links into the matrix, and the grow results go out row by row. A flush
// closes the sentence. The matrix is cleared in the end word's cycle, so no
// clearing pass is needed. New words are refused from the end word until its
// last result sits in the output register; a stalled result consumer stalls
// the scan. The user must write configuration only while idle; the block
// itself does not enforce it.

module word_alignment_symmetrizer import wasym_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [2:0] csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   wasym_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_data.action),
      .req_ready  (req_ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   wasym_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .stat      (stat)
   );

endmodule

// ===== verif/testbench.sv =====
// testbench: self-checking bench for word_alignment_symmetrizer
// depends on wasym_pkg and the word_alignment_symmetrizer rtl
`timescale 1ns / 1ps

module testbench;
   import wasym_pkg::*;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rsp_type    rsp_data;
   logic       csr_we = 1'b0;
   logic [1:0] csr_index = '0;
   logic [2:0] csr_wdata = '0;

   word_alignment_symmetrizer dut (.*);

   always #4 clock = ~clock;

   // predictor state
   logic [5:0]  src_links [MAX_SRC];
   logic [5:0]  tgt_links [MAX_TGT];
   logic [31:0] chosen [MAX_TGT];
   logic [31:0] src_cov, tgt_cov;
   logic [2:0]  cur_mode;
   logic        cur_diag, cur_final, cur_both;

   rsp_type pending_pairs[$];
   int      errors = 0;
   int      cycles = 0;
   bit      stall_enable = 1'b1;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 3000000) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // receiver stall pattern
   int stall_phase = 0;
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      if (!stall_enable) rsp_ready <= 1'b1;
      else if (stall_phase % 97 < 30) rsp_ready <= 1'b1;
      else rsp_ready <= ($urandom_range(0, 3) != 0);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pairs.size() == 0) begin
            errors++;
            $display("%0t unexpected word actual=%p", $time, rsp_data);
         end else begin
            rsp_type exp_w;
            exp_w = pending_pairs.pop_front();
            if (exp_w.error !== rsp_data.error || exp_w.last !== rsp_data.last ||
                exp_w.empty_res !== rsp_data.empty_res ||
                exp_w.src_index !== rsp_data.src_index ||
                exp_w.tgt_index !== rsp_data.tgt_index) begin
               errors++;
               $display("%0t mismatch expected=%p actual=%p", $time, exp_w, rsp_data);
            end
         end
      end
   end

   function automatic bit is_union(int t, int s);
      return tgt_links[t] == s + 1 || src_links[s] == t + 1;
   endfunction

   function automatic void mark(int t, int s);
      chosen[t][s] = 1'b1;
      tgt_cov[t] = 1'b1;
      src_cov[s] = 1'b1;
   endfunction

   function automatic bit final_allowed(int t, int s);
      if (cur_both) return !tgt_cov[t] && !src_cov[s];
      return !(tgt_cov[t] && src_cov[s]);
   endfunction

   function automatic void push_pair(int s, int t);
      rsp_type w;
      w = '0;
      w.src_index = s[4:0];
      w.tgt_index = t[4:0];
      pending_pairs.insert(pending_pairs.size(), w);
   endfunction

   function automatic void predict_grow(int m, int n);
      int dt[8] = '{-1, 0, 1, 0, -1, -1, 1, 1};
      int ds[8] = '{0, -1, 0, 1, -1, 1, -1, 1};
      int nn, pt, ps, l;
      bit grew;
      nn = cur_diag ? 8 : 4;
      for (int s = 0; s < m; s++) begin
         l = src_links[s];
         if (l != 0 && tgt_links[l - 1] == s + 1) mark(l - 1, s);
      end
      grew = 1'b1;
      while (grew) begin
         grew = 1'b0;
         for (int t = 0; t < n; t++)
            for (int s = 0; s < m; s++) begin
               if (!chosen[t][s]) continue;
               for (int o = 0; o < nn; o++) begin
                  pt = t + dt[o];
                  ps = s + ds[o];
                  if (pt < 0 || pt >= n || ps < 0 || ps >= m) continue;
                  if (!is_union(pt, ps)) continue;
                  if (!(tgt_cov[pt] && src_cov[ps])) begin
                     mark(pt, ps);
                     grew = 1'b1;
                  end
               end
            end
      end
      if (cur_final) begin
         for (int t = 0; t < n; t++)
            for (int s = 0; s < m; s++)
               if (!chosen[t][s] && tgt_links[t] == s + 1 && src_links[s] != t + 1 &&
                   final_allowed(t, s))
                  mark(t, s);
         for (int t = 0; t < n; t++)
            for (int s = 0; s < m; s++)
               if (!chosen[t][s] && src_links[s] == t + 1 && tgt_links[t] != s + 1 &&
                   final_allowed(t, s))
                  mark(t, s);
      end
      for (int t = 0; t < n; t++)
         for (int s = 0; s < m; s++)
            if (chosen[t][s]) push_pair(s, t);
   endfunction

   function automatic void predict_sentence(req_type w);
      int m, n, base, l;
      bit bad;
      rsp_type r;
      if (w.action == ACT_SRC) begin
         src_links[w.position] = w.link;
         return;
      end
      if (w.action == ACT_TGT) begin
         tgt_links[w.position] = w.link;
         return;
      end
      if (w.action != ACT_END) return;
      m = (w.src_len > MAX_SRC) ? MAX_SRC : w.src_len;
      n = (w.tgt_len > MAX_TGT) ? MAX_TGT : w.tgt_len;
      foreach (chosen[i]) chosen[i] = '0;
      src_cov = '0;
      tgt_cov = '0;
      bad = 1'b0;
      for (int s = 0; s < m; s++) if (src_links[s] > n) bad = 1'b1;
      for (int t = 0; t < n; t++) if (tgt_links[t] > m) bad = 1'b1;
      if (bad) begin
         r = '0;
         r.error = 1'b1;
         r.last = 1'b1;
         pending_pairs.insert(pending_pairs.size(), r);
         return;
      end
      base = pending_pairs.size();
      case (cur_mode)
         MODE_INTERSECT: begin
            for (int s = 0; s < m; s++) begin
               l = src_links[s];
               if (l != 0 && tgt_links[l - 1] == s + 1) push_pair(s, l - 1);
            end
         end
         MODE_GROW: predict_grow(m, n);
         MODE_S2T: begin
            for (int s = 0; s < m; s++)
               if (src_links[s] != 0) push_pair(s, src_links[s] - 1);
         end
         MODE_T2S: begin
            for (int t = 0; t < n; t++)
               if (tgt_links[t] != 0) push_pair(tgt_links[t] - 1, t);
         end
         default: begin
            for (int s = 0; s < m; s++)
               if (src_links[s] != 0) push_pair(s, src_links[s] - 1);
            for (int t = 0; t < n; t++) begin
               l = tgt_links[t];
               if (l != 0 && src_links[l - 1] != t + 1) push_pair(l - 1, t);
            end
         end
      endcase
      if (pending_pairs.size() == base) begin
         r = '0;
         r.empty_res = 1'b1;
         pending_pairs.insert(pending_pairs.size(), r);
      end
      r = pending_pairs[pending_pairs.size() - 1];
      r.last = 1'b1;
      pending_pairs[pending_pairs.size() - 1] = r;
   endfunction

   // sender bursts
   int burst_left = 0;

   task automatic send_word(req_type w);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         if ($urandom_range(0, 2) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      burst_left--;
      predict_sentence(w);
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_pairs.size() != 0) @(posedge clock);
      repeat (3000) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [2:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_MODE:  cur_mode = val;
         CSR_DIAG:  cur_diag = val[0];
         CSR_FINAL: cur_final = val[0];
         default:   cur_both = val[0];
      endcase
   endtask

   task automatic set_config(logic [2:0] md, bit dg, bit fs, bit bu);
      wait_idle();
      write_csr(CSR_MODE, md);
      write_csr(CSR_DIAG, {2'b0, dg});
      write_csr(CSR_FINAL, {2'b0, fs});
      write_csr(CSR_BOTH, {2'b0, bu});
      csr_we <= 1'b0;
   endtask

   function automatic req_type make_word(logic [1:0] act, int pos, int lnk, int sl, int tl);
      req_type w;
      w.action = act;
      w.position = pos[4:0];
      w.link = lnk[5:0];
      w.src_len = sl[5:0];
      w.tgt_len = tl[5:0];
      return w;
   endfunction

   // load the link slots of a sentence; full covers every slot
   task automatic load_sentence(int m, int n, bit sparse, bit allow_bad, bit full);
      int l, ms, nt;
      ms = full ? MAX_SRC : m;
      nt = full ? MAX_TGT : n;
      for (int s = 0; s < ms; s++) begin
         if (s >= m) l = $urandom_range(0, 63);
         else if (sparse && $urandom_range(0, 3) == 0) l = 0;
         else l = $urandom_range(0, n);
         if (allow_bad && s < m && $urandom_range(0, 40) == 0) l = $urandom_range(n + 1, 63);
         send_word(make_word(ACT_SRC, s, l, $urandom, $urandom));
      end
      for (int t = 0; t < nt; t++) begin
         if (t >= n) l = $urandom_range(0, 63);
         else if ($urandom_range(0, 2) == 0) begin
            // favor agreement so grow and intersect have points to work from
            l = 0;
            for (int s = 0; s < m; s++) if (src_links[s] == t + 1) l = s + 1;
         end else if (sparse && $urandom_range(0, 3) == 0) l = 0;
         else l = $urandom_range(0, m);
         if (allow_bad && t < n && $urandom_range(0, 40) == 0) l = $urandom_range(m + 1, 63);
         send_word(make_word(ACT_TGT, t, l, $urandom, $urandom));
      end
   endtask

   task automatic test_directed();
      // random links in every slot, source links then cleared, then extremes
      load_sentence(0, 0, 1'b0, 1'b0, 1'b1);
      for (int s = 0; s < MAX_SRC; s++) send_word(make_word(ACT_SRC, s, 0, 0, 0));
      send_word(make_word(ACT_END, 0, 0, 0, 0));
      send_word(make_word(ACT_END, 31, 63, 63, 63));
      send_word(make_word(ACT_NOP, 31, 63, 63, 63));
      send_word(make_word(ACT_SRC, 31, 32, 0, 0));
      send_word(make_word(ACT_TGT, 31, 32, 0, 0));
      send_word(make_word(ACT_SRC, 0, 1, 0, 0));
      send_word(make_word(ACT_TGT, 0, 1, 0, 0));
      send_word(make_word(ACT_END, 0, 0, 32, 32));
      send_word(make_word(ACT_END, 0, 0, 40, 63));
      // bad link: source 31 points past a short target
      send_word(make_word(ACT_END, 0, 0, 32, 5));
      send_word(make_word(ACT_SRC, 1, 63, 0, 0));
      send_word(make_word(ACT_END, 0, 0, 32, 32));
   endtask

   task automatic test_mode(logic [2:0] md, bit dg, bit fs, bit bu, int sentences);
      int m, n;
      set_config(md, dg, fs, bu);
      for (int k = 0; k < sentences; k++) begin
         if ($urandom_range(0, 7) == 0) begin
            m = 32;
            n = 32;
         end else begin
            m = $urandom_range(1, 8);
            n = $urandom_range(1, 8);
         end
         load_sentence(m, n, $urandom_range(0, 1), 1'b1, 1'b0);
         send_word(make_word(ACT_END, $urandom, $urandom, m, n));
      end
   endtask

   task automatic test_pause();
      // hold the sender until all results drained
      stall_enable = 1'b0;
      wait_idle();
      stall_enable = 1'b1;
      send_word(make_word(ACT_END, 0, 0, 3, 3));
   endtask

   initial begin
      foreach (src_links[i]) src_links[i] = '0;
      foreach (tgt_links[i]) tgt_links[i] = '0;
      cur_mode = MODE_UNION;
      cur_diag = 1'b0;
      cur_final = 1'b0;
      cur_both = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_mode(MODE_INTERSECT, 1'b0, 1'b0, 1'b0, 1);
      test_mode(MODE_GROW, 1'b1, 1'b1, 1'b1, 1);
      test_mode(MODE_S2T, 1'b0, 1'b0, 1'b0, 1);
      test_mode(MODE_T2S, 1'b0, 1'b0, 1'b0, 1);
      test_mode(3'd7, 1'b0, 1'b0, 1'b0, 1);
      test_pause();
      test_mode(MODE_GROW, 1'b0, 1'b0, 1'b0, 2);
      test_mode(MODE_GROW, 1'b1, 1'b0, 1'b0, 2);
      test_mode(MODE_GROW, 1'b1, 1'b1, 1'b0, 2);
      test_mode(MODE_GROW, 1'b0, 1'b1, 1'b1, 2);
      test_mode(MODE_UNION, 1'b0, 1'b0, 1'b0, 1);
      test_mode(3'd5, 1'b1, 1'b1, 1'b1, 1);
      wait_idle();
      if (errors == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/wasym_pkg.sv
rtl/wasym_ctrl.sv
rtl/wasym_dp.sv
rtl/word_alignment_symmetrizer.sv
verif/testbench.sv
